### hw/rtl/kfli_pkg.sv
// Shared types and constants of the keyframe interpolation table.
`default_nettype none

package kfli_pkg;

  localparam int unsigned AGE_W   = 12;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned PROB_W  = 16;
  // Value and probability both widen to one signed operand format.
  localparam int unsigned OPD_W   = 17;
  localparam int unsigned DIFF_W  = OPD_W + 1;
  localparam int unsigned MAG_W   = 17;
  localparam int unsigned PROD_W  = MAG_W + AGE_W;
  localparam int unsigned DCNT_W  = $clog2(PROD_W + 1);

  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_QUERY   = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [AGE_W-1:0]         age;
    logic signed [VAL_W-1:0]  value;
    logic [PROB_W-1:0]        prob;
  } entry_t;

  typedef struct packed {
    logic load_in;
    logic rd_en;
    logic rd_prev;
    logic idx_inc;
    logic idx_dec;
    logic idx_cnt;
    logic pos_idx;
    logic pos_cnt;
    logic wr_shift;
    logic wr_new;
    logic lo_load;
    logic mul;
    logic div_start;
    logic sel_prob;
    logic res_clr;
    logic res_full;
    logic res_exact;
    logic res_fix;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic query;
    logic full;
    logic empty;
    logic eq;
    logic lt;
    logic last;
    logic at_pos;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/kfli_if.sv
// Request and response channel interfaces of the keyframe interpolation table.
`default_nettype none

interface kfli_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [kfli_pkg::AGE_W-1:0]          key_age;
  logic signed [kfli_pkg::VAL_W-1:0]   point_value;
  logic [kfli_pkg::PROB_W-1:0]         point_prob;

  modport source (output valid, req_type, key_age, point_value, point_prob, input ready);
  modport sink   (input valid, req_type, key_age, point_value, point_prob, output ready);
endinterface

interface kfli_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [kfli_pkg::VAL_W-1:0]   out_value;
  logic [kfli_pkg::PROB_W-1:0]         out_prob;
  logic                                in_range;
  logic                                status;

  modport source (output valid, out_value, out_prob, in_range, status, input ready);
  modport sink   (input valid, out_value, out_prob, in_range, status, output ready);
endinterface

`default_nettype wire

### hw/rtl/kfli_div.sv
// Restoring divider, one quotient bit per cycle, for the interpolation step.
`default_nettype none

module kfli_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [kfli_pkg::PROD_W-1:0]  dividend_i,
  input  logic [kfli_pkg::AGE_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [kfli_pkg::PROD_W-1:0]  quot_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [kfli_pkg::DCNT_W-1:0]   cnt_q;
  logic [kfli_pkg::AGE_W-1:0]    div_q;
  logic [kfli_pkg::AGE_W-1:0]    rem_q;
  logic [kfli_pkg::AGE_W-1:0]    rem_d;
  logic [kfli_pkg::PROD_W-1:0]   work_q;
  logic [kfli_pkg::AGE_W:0]      rem_sh;
  logic                          q_bit;

  // Remainder stays below the divisor, so one extra bit holds the shifted value.
  always_comb begin
    rem_sh = {rem_q, work_q[kfli_pkg::PROD_W-1]};
    q_bit  = (rem_sh >= {1'b0, div_q});
    if (q_bit) begin
      rem_d = kfli_pkg::AGE_W'(rem_sh - {1'b0, div_q});
    end else begin
      rem_d = rem_sh[kfli_pkg::AGE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == kfli_pkg::DCNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= kfli_pkg::DCNT_W'(kfli_pkg::PROD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - kfli_pkg::DCNT_W'(1);
        if (cnt_q == kfli_pkg::DCNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      div_q  <= divisor_i;
      work_q <= dividend_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      work_q <= {work_q[kfli_pkg::PROD_W-2:0], q_bit};
    end
  end

  assign done_o = done_q;
  assign quot_o = work_q;

endmodule

`default_nettype wire

### hw/rtl/kfli_dp.sv
// Datapath: keyframe memory, scan registers, multiplier, divider and result registers.
`default_nettype none

module kfli_dp #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_type_i,
  input  logic [kfli_pkg::AGE_W-1:0]        key_age_i,
  input  logic signed [kfli_pkg::VAL_W-1:0] point_value_i,
  input  logic [kfli_pkg::PROB_W-1:0]       point_prob_i,
  input  logic                              out_ready_i,
  input  kfli_pkg::cmd_t                    cmd_i,
  output kfli_pkg::sts_t                    sts_o,
  output logic                              out_valid_o,
  output logic signed [kfli_pkg::VAL_W-1:0] out_value_o,
  output logic [kfli_pkg::PROB_W-1:0]       out_prob_o,
  output logic                              in_range_o,
  output logic                              status_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  kfli_pkg::entry_t mem_q [MAX_POINTS];
  kfli_pkg::entry_t rd_q;
  kfli_pkg::entry_t lo_q;
  kfli_pkg::entry_t new_entry;

  logic [CW-1:0]                    cnt_q;
  logic [CW-1:0]                    idx_q;
  logic [CW-1:0]                    pos_q;
  logic [CW-1:0]                    idx_prev;
  logic [AW-1:0]                    rd_addr;
  logic [AW-1:0]                    wr_addr;
  kfli_pkg::entry_t                 wr_data;

  logic                             req_q;
  logic [kfli_pkg::AGE_W-1:0]       age_q;
  logic signed [kfli_pkg::VAL_W-1:0] val_q;
  logic [kfli_pkg::PROB_W-1:0]      prob_q;

  logic signed [kfli_pkg::OPD_W-1:0]  lo_opd;
  logic signed [kfli_pkg::OPD_W-1:0]  hi_opd;
  logic signed [kfli_pkg::DIFF_W-1:0] diff;
  logic [kfli_pkg::DIFF_W-1:0]        mag_full;
  logic [kfli_pkg::MAG_W-1:0]         mag;
  logic [kfli_pkg::AGE_W-1:0]         age_off;
  logic [kfli_pkg::AGE_W-1:0]         span;
  logic [kfli_pkg::PROD_W-1:0]        prod_q;
  logic                               neg_q;
  logic [kfli_pkg::PROD_W-1:0]        quot;
  logic                               div_done;
  logic [kfli_pkg::DIFF_W-1:0]        q_ext;
  logic [kfli_pkg::DIFF_W-1:0]        fix_sum;

  logic signed [kfli_pkg::VAL_W-1:0] res_val_q;
  logic [kfli_pkg::PROB_W-1:0]       res_prob_q;
  logic                              res_in_q;
  logic                              res_st_q;

  logic                              out_vld_q;
  logic signed [kfli_pkg::VAL_W-1:0] out_val_q;
  logic [kfli_pkg::PROB_W-1:0]       out_prob_q;
  logic                              out_in_q;
  logic                              out_st_q;

  assign new_entry = '{age: age_q, value: val_q, prob: prob_q};
  assign idx_prev  = idx_q - CW'(1);
  assign rd_addr   = cmd_i.rd_prev ? idx_prev[AW-1:0] : idx_q[AW-1:0];
  assign wr_addr   = cmd_i.wr_new ? pos_q[AW-1:0] : idx_q[AW-1:0];
  assign wr_data   = cmd_i.wr_new ? new_entry : rd_q;

  // Keyframe memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_new || cmd_i.wr_shift) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      idx_q     <= '0;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.wr_new) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.load_in) begin
        idx_q <= '0;
      end else if (cmd_i.idx_cnt) begin
        idx_q <= cnt_q;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CW'(1);
      end else if (cmd_i.idx_dec) begin
        idx_q <= idx_prev;
      end
      if (cmd_i.pos_idx) begin
        pos_q <= idx_q;
      end else if (cmd_i.pos_cnt) begin
        pos_q <= cnt_q;
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Operand formats: value sign-extends, probability zero-extends.
  always_comb begin
    if (cmd_i.sel_prob) begin
      lo_opd = $signed({1'b0, lo_q.prob});
      hi_opd = $signed({1'b0, rd_q.prob});
    end else begin
      lo_opd = $signed({lo_q.value[kfli_pkg::VAL_W-1], lo_q.value});
      hi_opd = $signed({rd_q.value[kfli_pkg::VAL_W-1], rd_q.value});
    end
    diff     = $signed({hi_opd[kfli_pkg::OPD_W-1], hi_opd})
             - $signed({lo_opd[kfli_pkg::OPD_W-1], lo_opd});
    mag_full = diff[kfli_pkg::DIFF_W-1] ? kfli_pkg::DIFF_W'(-diff) : kfli_pkg::DIFF_W'(diff);
    mag      = mag_full[kfli_pkg::MAG_W-1:0];
    age_off  = age_q - lo_q.age;
    span     = rd_q.age - lo_q.age;
    q_ext    = {1'b0, quot[kfli_pkg::MAG_W-1:0]};
    fix_sum  = kfli_pkg::DIFF_W'({lo_opd[kfli_pkg::OPD_W-1], lo_opd})
             + (neg_q ? kfli_pkg::DIFF_W'(-q_ext) : q_ext);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      req_q  <= req_type_i;
      age_q  <= key_age_i;
      val_q  <= point_value_i;
      prob_q <= point_prob_i;
      // The scan starts from an all-zero origin below the first keyframe.
      lo_q   <= '0;
    end else if (cmd_i.lo_load) begin
      lo_q <= rd_q;
    end
    if (cmd_i.mul) begin
      prod_q <= {{kfli_pkg::MAG_W{1'b0}}, age_off} * {{kfli_pkg::AGE_W{1'b0}}, mag};
      neg_q  <= diff[kfli_pkg::DIFF_W-1];
    end
    if (cmd_i.res_clr || cmd_i.res_full) begin
      res_val_q  <= '0;
      res_prob_q <= '0;
      res_in_q   <= 1'b0;
      res_st_q   <= cmd_i.res_full ? kfli_pkg::STATUS_FULL : kfli_pkg::STATUS_OK;
    end else if (cmd_i.res_exact) begin
      res_val_q  <= rd_q.value;
      res_prob_q <= rd_q.prob;
      res_in_q   <= 1'b1;
      res_st_q   <= kfli_pkg::STATUS_OK;
    end else if (cmd_i.res_fix) begin
      if (cmd_i.sel_prob) begin
        res_prob_q <= fix_sum[kfli_pkg::PROB_W-1:0];
      end else begin
        res_val_q  <= $signed(fix_sum[kfli_pkg::VAL_W-1:0]);
      end
      res_in_q <= 1'b1;
      res_st_q <= kfli_pkg::STATUS_OK;
    end
    if (cmd_i.out_load) begin
      out_val_q  <= res_val_q;
      out_prob_q <= res_prob_q;
      out_in_q   <= res_in_q;
      out_st_q   <= res_st_q;
    end
  end

  kfli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (span),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    sts_o.query    = (req_q == kfli_pkg::REQ_QUERY);
    sts_o.full     = (cnt_q == CW'(MAX_POINTS));
    sts_o.empty    = (cnt_q == '0);
    sts_o.eq       = (rd_q.age == age_q);
    sts_o.lt       = (rd_q.age < age_q);
    sts_o.last     = ((idx_q + CW'(1)) == cnt_q);
    sts_o.at_pos   = (idx_q == pos_q);
    sts_o.div_done = div_done;
    sts_o.out_free = !out_vld_q || out_ready_i;
  end

  assign out_valid_o = out_vld_q;
  assign out_value_o = out_val_q;
  assign out_prob_o  = out_prob_q;
  assign in_range_o  = out_in_q;
  assign status_o    = out_st_q;

endmodule

`default_nettype wire

### hw/rtl/kfli_ctrl.sv
// Controller: sequences the insert scan and shift, the query scan and the two divisions.
`default_nettype none

module kfli_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  kfli_pkg::sts_t  sts_i,
  output kfli_pkg::cmd_t  cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DISP   = 11'b000_0000_0010,
    S_RD     = 11'b000_0000_0100,
    S_CMP    = 11'b000_0000_1000,
    S_SH_RD  = 11'b000_0001_0000,
    S_SH_WR  = 11'b000_0010_0000,
    S_WR     = 11'b000_0100_0000,
    S_MUL    = 11'b000_1000_0000,
    S_DSTART = 11'b001_0000_0000,
    S_DWAIT  = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   sel_q, sel_d;

  always_comb begin
    state_d          = state_q;
    sel_d            = sel_q;
    cmd_o            = '0;
    cmd_o.sel_prob   = sel_q;
    in_ready_o       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        sel_d      = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.query) begin
          if (sts_i.empty) begin
            cmd_o.res_clr = 1'b1;
            state_d       = S_DONE;
          end else begin
            state_d = S_RD;
          end
        end else if (sts_i.full) begin
          cmd_o.res_full = 1'b1;
          state_d        = S_DONE;
        end else if (sts_i.empty) begin
          cmd_o.pos_cnt = 1'b1;
          cmd_o.idx_cnt = 1'b1;
          state_d       = S_SH_RD;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CMP;
      end
      S_CMP: begin
        if (sts_i.query) begin
          if (sts_i.eq) begin
            cmd_o.res_exact = 1'b1;
            state_d         = S_DONE;
          end else if (sts_i.lt) begin
            cmd_o.lo_load = 1'b1;
            if (sts_i.last) begin
              // Past the last keyframe: zeros with in_range clear.
              cmd_o.res_clr = 1'b1;
              state_d       = S_DONE;
            end else begin
              cmd_o.idx_inc = 1'b1;
              state_d       = S_RD;
            end
          end else begin
            state_d = S_MUL;
          end
        end else if (!sts_i.lt) begin
          cmd_o.pos_idx = 1'b1;
          cmd_o.idx_cnt = 1'b1;
          state_d       = S_SH_RD;
        end else if (sts_i.last) begin
          cmd_o.pos_cnt = 1'b1;
          cmd_o.idx_cnt = 1'b1;
          state_d       = S_SH_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_RD;
        end
      end
      S_SH_RD: begin
        if (sts_i.at_pos) begin
          state_d = S_WR;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_prev = 1'b1;
          state_d       = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_dec  = 1'b1;
        state_d        = S_SH_RD;
      end
      S_WR: begin
        cmd_o.wr_new  = 1'b1;
        cmd_o.res_clr = 1'b1;
        state_d       = S_DONE;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DSTART;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.res_fix = 1'b1;
          if (sel_q) begin
            state_d = S_DONE;
          end else begin
            sel_d   = 1'b1;
            state_d = S_MUL;
          end
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/keyframe_linear_interpolation_table_core.sv
// Top level of the keyframe table with piecewise linear interpolation.
//
//   Channel  Role   Payload                                      Transaction
//   in_i     sink   req_type, key_age, point_value, point_prob   valid && ready
//   out_o    source out_value, out_prob, in_range, status        valid && ready
//
// One request is in work at a time; in_i.ready is high only while the controller is idle.
// Insert: scans the entries in order, shifts each later entry up one slot, then writes.
// Query: scans the entries in order; an interpolation adds two divisions on the shared
// one-bit-per-cycle divider, one for the value and one for the probability (29-bit quotients).
// Reset empties the table at once; the result register lets a new request start
// while out_o is stalled, and the controller waits there only to hand over the next result.
`default_nettype none

module keyframe_linear_interpolation_table_core #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kfli_in_if.sink     in_i,
  kfli_out_if.source  out_o
);

  kfli_pkg::cmd_t cmd;
  kfli_pkg::sts_t sts;

  kfli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kfli_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_type_i    (in_i.req_type),
    .key_age_i     (in_i.key_age),
    .point_value_i (in_i.point_value),
    .point_prob_i  (in_i.point_prob),
    .out_ready_i   (out_o.ready),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .out_value_o   (out_o.out_value),
    .out_prob_o    (out_o.out_prob),
    .in_range_o    (out_o.in_range),
    .status_o      (out_o.status)
  );

`ifndef SYNTHESIS
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("new request taken while one is in work");

  a_full_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status |->
      !out_o.in_range && out_o.out_value == '0 && out_o.out_prob == '0)
    else $error("dropped insert carries nonzero result fields");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_new |-> !sts.full)
    else $error("keyframe written into a full table");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten before its transaction");
`endif

endmodule

`default_nettype wire

### verif/keyframe_table_checker.sv
// Scoreboard for the keyframe table: predicts every reply and compares it with the block.
`timescale 1ns / 1ps

module keyframe_table_checker #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  kfli_in_if   req_ch,
  kfli_out_if  rsp_ch,
  output int   fail_count_o,
  output int   replies_owed_o,
  output int   replies_seen_o
);

  localparam int unsigned CHK_W = kfli_pkg::VAL_W + 1;

  typedef struct packed {
    logic signed [kfli_pkg::VAL_W-1:0] value;
    logic [kfli_pkg::PROB_W-1:0]       prob;
    logic                              in_range;
    logic                              status;
  } table_reply_t;

  // Shadow copy of the keyframe table, kept sorted by age like the block's.
  logic [kfli_pkg::AGE_W-1:0]        kf_age   [MAX_POINTS];
  logic signed [kfli_pkg::VAL_W-1:0] kf_value [MAX_POINTS];
  logic [kfli_pkg::PROB_W-1:0]       kf_prob  [MAX_POINTS];
  int                                kf_count = 0;

  table_reply_t            owed_replies[$];
  int                      fail_count = 0;
  int                      replies_seen = 0;

  assign fail_count_o   = fail_count;
  assign replies_seen_o = replies_seen;

  function automatic table_reply_t apply_table_request(
    input logic                              kind,
    input logic [kfli_pkg::AGE_W-1:0]        age,
    input logic signed [kfli_pkg::VAL_W-1:0] value,
    input logic [kfli_pkg::PROB_W-1:0]       prob
  );
    table_reply_t reply;
    int           slot;
    int           i;
    longint       lo_age;
    longint       lo_val;
    longint       lo_prob;
    longint       age_off;
    longint       span;
    reply = '0;
    if (kind == kfli_pkg::REQ_INSERT) begin
      if (kf_count >= MAX_POINTS) begin
        reply.status = kfli_pkg::STATUS_FULL;
      end else begin
        // A new keyframe lands before any stored one of the same age.
        slot = kf_count;
        for (i = 0; i < kf_count; i++) begin
          if (kf_age[i] >= age) begin
            slot = i;
            break;
          end
        end
        for (i = kf_count; i > slot; i--) begin
          kf_age[i]   = kf_age[i-1];
          kf_value[i] = kf_value[i-1];
          kf_prob[i]  = kf_prob[i-1];
        end
        kf_age[slot]   = age;
        kf_value[slot] = value;
        kf_prob[slot]  = prob;
        kf_count++;
      end
    end else begin
      // Below the first keyframe the lower end is the all-zero origin.
      lo_age  = 0;
      lo_val  = 0;
      lo_prob = 0;
      for (i = 0; i < kf_count; i++) begin
        if (kf_age[i] == age) begin
          reply.value    = kf_value[i];
          reply.prob     = kf_prob[i];
          reply.in_range = 1'b1;
          break;
        end else if (kf_age[i] < age) begin
          lo_age  = longint'(kf_age[i]);
          lo_val  = longint'(kf_value[i]);
          lo_prob = longint'(kf_prob[i]);
        end else begin
          age_off = longint'(age) - lo_age;
          span    = longint'(kf_age[i]) - lo_age;
          // SystemVerilog division truncates toward zero, as the block does.
          reply.value    = kfli_pkg::VAL_W'(
              lo_val + (age_off * (longint'(kf_value[i]) - lo_val)) / span);
          reply.prob     = kfli_pkg::PROB_W'(
              lo_prob + (age_off * (longint'(kf_prob[i]) - lo_prob)) / span);
          reply.in_range = 1'b1;
          break;
        end
      end
    end
    return reply;
  endfunction

  task automatic check_field(
    input string                  field,
    input logic signed [CHK_W-1:0] want,
    input logic signed [CHK_W-1:0] got
  );
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_reply_t reply;
    if (!rst_ni) begin
      kf_count = 0;
      owed_replies.delete();
      replies_owed_o <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        owed_replies.push_back(apply_table_request(req_ch.req_type, req_ch.key_age,
                                                   req_ch.point_value, req_ch.point_prob));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        replies_seen++;
        if (owed_replies.size() == 0) begin
          $display("%0t: reply transaction with no request outstanding", $time);
          fail_count++;
        end else begin
          reply = owed_replies.pop_front();
          check_field("out_value", CHK_W'(reply.value), CHK_W'(rsp_ch.out_value));
          check_field("out_prob", CHK_W'(reply.prob), CHK_W'(rsp_ch.out_prob));
          check_field("in_range", CHK_W'(reply.in_range), CHK_W'(rsp_ch.in_range));
          check_field("status", CHK_W'(reply.status), CHK_W'(rsp_ch.status));
        end
      end
      replies_owed_o <= owed_replies.size();
    end
  end

endmodule

### verif/testbench.sv
// Top of the keyframe table testbench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TABLE_DEPTH  = 16;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned AGE_MAX      = (1 << kfli_pkg::AGE_W) - 1;
  localparam logic [kfli_pkg::AGE_W-1:0] AGE_LAST = '1;

  logic clk_i = 1'b0;
  logic rst_ni;

  kfli_in_if  req_ch();
  kfli_out_if rsp_ch();

  int fail_count;
  int replies_owed;
  int replies_seen;
  int inserts_sent = 0;
  int queries_sent = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  logic [kfli_pkg::AGE_W-1:0] stored_ages[$];

  always #5 clk_i = ~clk_i;

  keyframe_linear_interpolation_table_core #(
    .MAX_POINTS(TABLE_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch),
    .out_o (rsp_ch)
  );

  keyframe_table_checker #(
    .MAX_POINTS(TABLE_DEPTH)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_ch        (req_ch),
    .rsp_ch        (rsp_ch),
    .fail_count_o  (fail_count),
    .replies_owed_o(replies_owed),
    .replies_seen_o(replies_seen)
  );

  // Mostly short gaps, now and then a long one, none at all during calm stretches.
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(
    input logic                              kind,
    input logic [kfli_pkg::AGE_W-1:0]        age,
    input logic signed [kfli_pkg::VAL_W-1:0] value,
    input logic [kfli_pkg::PROB_W-1:0]       prob
  );
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.key_age     <= age;
    req_ch.point_value <= value;
    req_ch.point_prob  <= prob;
    do @(posedge clk_i); while (!req_ch.ready);
    if (kind == kfli_pkg::REQ_INSERT) inserts_sent++;
    else queries_sent++;
  endtask

  task automatic insert_keyframe(
    input logic [kfli_pkg::AGE_W-1:0]        age,
    input logic signed [kfli_pkg::VAL_W-1:0] value,
    input logic [kfli_pkg::PROB_W-1:0]       prob
  );
    if (stored_ages.size() < TABLE_DEPTH) stored_ages.push_back(age);
    send_request(kfli_pkg::REQ_INSERT, age, value, prob);
  endtask

  // The point fields of a query are ignored, so they carry random bits.
  task automatic query_age(input logic [kfli_pkg::AGE_W-1:0] age);
    send_request(kfli_pkg::REQ_QUERY, age, kfli_pkg::VAL_W'($urandom),
                 kfli_pkg::PROB_W'($urandom));
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (replies_owed != 0);
  endtask

  // Queries cluster on stored ages and their neighbors, where the scan decides the most.
  function automatic logic [kfli_pkg::AGE_W-1:0] pick_query_age();
    int base;
    if (stored_ages.size() == 0 || $urandom_range(0, 99) < 35) begin
      return kfli_pkg::AGE_W'($urandom_range(0, AGE_MAX));
    end
    base = int'(stored_ages[$urandom_range(0, stored_ages.size() - 1)]);
    base = base + int'($urandom_range(0, 2)) - 1;
    if (base < 0) base = 0;
    if (base > int'(AGE_MAX)) base = int'(AGE_MAX);
    return base[kfli_pkg::AGE_W-1:0];
  endfunction

  function automatic logic [kfli_pkg::AGE_W-1:0] pick_insert_age();
    if (stored_ages.size() != 0 && $urandom_range(0, 99) < 20) begin
      return stored_ages[$urandom_range(0, stored_ages.size() - 1)];
    end
    return kfli_pkg::AGE_W'($urandom_range(0, AGE_MAX));
  endfunction

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        rsp_ch.ready <= 1'b0;
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(0, 2);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles, %0d replies outstanding", CYCLE_LIMIT, replies_owed);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_ni             <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= kfli_pkg::REQ_INSERT;
    req_ch.key_age     <= '0;
    req_ch.point_value <= '0;
    req_ch.point_prob  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, extremes, equal ages, origin and beyond-last queries.
    query_age('0);
    query_age(AGE_LAST);
    insert_keyframe(12'd100, 16'sh7fff, 16'hffff);
    query_age(12'd100);
    query_age(12'd50);
    query_age(12'd101);
    insert_keyframe(12'd100, 16'sh8000, 16'h0000);
    query_age(12'd100);
    query_age(12'd99);
    insert_keyframe('0, -16'sd1, 16'h0001);
    query_age('0);
    query_age(12'd1);
    insert_keyframe(AGE_LAST, 16'sd1, 16'hffff);
    query_age(AGE_LAST);
    query_age(12'd2000);
    insert_keyframe(AGE_LAST, 16'sh7fff, 16'h8000);
    query_age(AGE_LAST);
    query_age(AGE_LAST - 12'd1);
    send_request(kfli_pkg::REQ_QUERY, 12'd101, 16'sh7fff, 16'hffff);
    wait_drained();

    // Random part: the table fills slowly, later inserts find it full.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = ((i / 128) % 4 == 2);
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if ($urandom_range(0, 99) < ((stored_ages.size() < TABLE_DEPTH) ? 8 : 3)) begin
        insert_keyframe(pick_insert_age(), kfli_pkg::VAL_W'($urandom),
                        kfli_pkg::PROB_W'($urandom));
      end else begin
        query_age(pick_query_age());
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Summary: %0d inserts and %0d queries driven, %0d replies checked.",
             inserts_sent, queries_sent, replies_seen);
    $display({"Covered exact hits, interpolation from origin and between keyframes, ",
              "queries past the last keyframe and inserts into a full table."});
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/kfli_pkg.sv
hw/rtl/kfli_if.sv
hw/rtl/kfli_div.sv
hw/rtl/kfli_dp.sv
hw/rtl/kfli_ctrl.sv
hw/rtl/keyframe_linear_interpolation_table_core.sv
verif/keyframe_table_checker.sv
verif/testbench.sv
